FILE: hdl/bcm_pkg.sv
package bcm_pkg;

    localparam int NUM_BUFFERS = 16;
    localparam int IDX_BITS    = $clog2(NUM_BUFFERS);
    localparam int COUNT_BITS  = $clog2(NUM_BUFFERS + 1);
    localparam int SUM_BITS    = COUNT_BITS + 1;
    localparam int DEV_BITS    = 4;
    localparam int BLOCK_BITS  = 32;
    localparam int REFS_BITS   = 8;
    localparam int SHIFT_BITS  = 3;
    localparam int SECTOR_BITS = 39;

    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = SHIFT_BITS'(3);
    localparam logic [REFS_BITS-1:0]  REFS_MAX    = '1;

    typedef enum logic [1:0] {
        REQ_GET       = 2'd0,
        REQ_RELEASE   = 2'd1,
        REQ_READ_FAIL = 2'd2,
        REQ_RESERVED  = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_NO_FREE = 3'd2,
        ST_HELD    = 3'd3,
        ST_FREED   = 3'd4,
        ST_REL_ERR = 3'd5,
        ST_REFUSED = 3'd6
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [DEV_BITS-1:0]   dev_id;
        logic [BLOCK_BITS-1:0] block_num;
        logic [IDX_BITS-1:0]   buf_index;
    } t_request;

    typedef struct packed {
        logic [2:0]             status;
        logic [IDX_BITS-1:0]    out_index;
        logic                   read_valid;
        logic [DEV_BITS-1:0]    read_dev;
        logic [SECTOR_BITS-1:0] read_sector;
    } t_result;

endpackage

FILE: hdl/block_buffer_cache_manager.sv
// Channel    | Direction | Handshake                    | Payload
// -----------+-----------+------------------------------+---------------------------
// request    | in        | start & !busy                | i_req (bcm_pkg::t_request)
// result     | out       | o_res_valid, one cycle only  | o_res (bcm_pkg::t_result)
// config     | in        | i_cfg_valid & o_cfg_ready    | i_cfg_data (sector shift)
//
// A request passes through an accept cycle and an execute cycle: the accept cycle runs
// the tag compare and reads the reference count memory and the free-list memory; the
// execute cycle (busy high) does the read-modify-write and drives the result strobe.
// busy stays high through the execute cycle, so the block takes no new request until
// the execute cycle of the last one is over.
// Reset is synchronous, active low; no clearing pass: the free list is seeded by
// per-slot valid bits, so the block takes requests from the first cycle after reset.
// The receiver cannot stall: every result is presented for exactly one cycle.
module block_buffer_cache_manager (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bcm_pkg::t_request                   i_req,
    output logic                                o_res_valid,
    output bcm_pkg::t_result                    o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bcm_pkg::SHIFT_BITS-1:0]      i_cfg_data
);

    // Sequencer state
    bcm_pkg::t_state r_state, n_state;

    // Configuration
    logic [bcm_pkg::SHIFT_BITS-1:0] r_sector_shift;

    // Tag store: held in flops so every entry sees the parallel compare
    logic [bcm_pkg::NUM_BUFFERS-1:0] r_in_use;
    logic [bcm_pkg::DEV_BITS-1:0]    r_dev   [bcm_pkg::NUM_BUFFERS];
    logic [bcm_pkg::BLOCK_BITS-1:0]  r_block [bcm_pkg::NUM_BUFFERS];

    // Reference counts: synchronous memory, registered read
    logic [bcm_pkg::REFS_BITS-1:0] refs_mem [bcm_pkg::NUM_BUFFERS];
    logic [bcm_pkg::REFS_BITS-1:0] r_refs_rd;

    // Free list: synchronous memory plus a written flag per slot; a slot never
    // written reads as its own number, which gives the in-order seed after reset
    logic [bcm_pkg::IDX_BITS-1:0]    fq_mem [bcm_pkg::NUM_BUFFERS];
    logic [bcm_pkg::NUM_BUFFERS-1:0] r_fq_ok;
    logic [bcm_pkg::IDX_BITS-1:0]    r_fq_rd;
    logic                            r_fq_rd_ok;
    logic [bcm_pkg::IDX_BITS-1:0]    r_fq_rd_slot;
    logic [bcm_pkg::IDX_BITS-1:0]    r_free_head, n_free_head;
    logic [bcm_pkg::COUNT_BITS-1:0]  r_free_count, n_free_count;

    // Request held across the execute cycle, with the compare outcome
    bcm_pkg::t_request               r_req;
    logic                            r_hit;
    logic [bcm_pkg::IDX_BITS-1:0]    r_hit_idx;

    logic                            accept;
    logic                            match_any;
    logic [bcm_pkg::IDX_BITS-1:0]    match_idx;
    logic [bcm_pkg::IDX_BITS-1:0]    refs_raddr;

    // Execute-cycle controls
    logic                            ref_we;
    logic [bcm_pkg::IDX_BITS-1:0]    ref_waddr;
    logic [bcm_pkg::REFS_BITS-1:0]   ref_wdata;
    logic                            bind_en;
    logic                            unbind_en;
    logic                            push_en;
    logic [bcm_pkg::IDX_BITS-1:0]    pop_idx;
    logic [bcm_pkg::SUM_BITS-1:0]    tail_sum;
    logic [bcm_pkg::IDX_BITS-1:0]    tail_idx;
    bcm_pkg::t_result                res;

    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bcm_pkg::S_IDLE: if (accept) n_state = bcm_pkg::S_EXEC;
            bcm_pkg::S_EXEC: n_state = bcm_pkg::S_IDLE;
            default:         n_state = bcm_pkg::S_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        busy        = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            bcm_pkg::S_IDLE: begin
                busy        = 1'b0;
                o_res_valid = 1'b0;
            end
            bcm_pkg::S_EXEC: begin
                busy        = 1'b1;
                o_res_valid = 1'b1;
            end
            default: begin
                busy        = 1'b0;
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration write: taken only while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_shift <= bcm_pkg::SHIFT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sector_shift <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------------
    // Accept cycle: tag compare, lowest matching index wins
    // ---------------------------------------------------------------------
    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = bcm_pkg::NUM_BUFFERS - 1; i >= 0; i--) begin
            if (r_in_use[i] && r_dev[i] == i_req.dev_id && r_block[i] == i_req.block_num) begin
                match_any = 1'b1;
                match_idx = bcm_pkg::IDX_BITS'(i);
            end
        end
    end

    // Get reads the matching entry's count; release and read-fail read the named one
    assign refs_raddr = (i_req.req_type == bcm_pkg::REQ_GET) ? match_idx : i_req.buf_index;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= i_req;
            r_hit     <= match_any && (i_req.req_type == bcm_pkg::REQ_GET);
            r_hit_idx <= match_idx;
        end
    end

    // Reference count memory: read in the accept cycle, written back in execute.
    // The two never meet on one item, and the interlock keeps items apart.
    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            refs_mem[ref_waddr] <= ref_wdata;
        end
        r_refs_rd <= refs_mem[refs_raddr];
    end

    // Free-list memory: pop side read at the head, push side written at the tail
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            fq_mem[tail_idx] <= r_req.buf_index;
        end
        r_fq_rd      <= fq_mem[r_free_head];
        r_fq_rd_ok   <= r_fq_ok[r_free_head];
        r_fq_rd_slot <= r_free_head;
    end

    assign pop_idx  = r_fq_rd_ok ? r_fq_rd : r_fq_rd_slot;
    assign tail_sum = bcm_pkg::SUM_BITS'(r_free_head) + bcm_pkg::SUM_BITS'(r_free_count);
    assign tail_idx = (tail_sum >= bcm_pkg::SUM_BITS'(bcm_pkg::NUM_BUFFERS))
                    ? bcm_pkg::IDX_BITS'(tail_sum - bcm_pkg::SUM_BITS'(bcm_pkg::NUM_BUFFERS))
                    : bcm_pkg::IDX_BITS'(tail_sum);

    // ---------------------------------------------------------------------
    // Execute cycle: decide, modify, write back, present the result
    // ---------------------------------------------------------------------
    always_comb begin
        ref_we       = 1'b0;
        ref_waddr    = r_req.buf_index;
        ref_wdata    = '0;
        bind_en      = 1'b0;
        unbind_en    = 1'b0;
        push_en      = 1'b0;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        res          = '0;

        if (r_state == bcm_pkg::S_EXEC) begin
            unique case (r_req.req_type)
                bcm_pkg::REQ_GET: begin
                    if (r_hit) begin
                        res.out_index = r_hit_idx;
                        if (r_refs_rd == bcm_pkg::REFS_MAX) begin
                            // Count would overflow: refuse, leave it alone
                            res.status = bcm_pkg::ST_REFUSED;
                        end else begin
                            res.status = bcm_pkg::ST_HIT;
                            ref_we     = 1'b1;
                            ref_waddr  = r_hit_idx;
                            ref_wdata  = r_refs_rd + bcm_pkg::REFS_BITS'(1);
                        end
                    end else if (r_free_count == '0) begin
                        res.status = bcm_pkg::ST_NO_FREE;
                    end else begin
                        // Miss: pop the oldest free buffer, bind it, issue the read
                        res.status      = bcm_pkg::ST_MISS;
                        res.out_index   = pop_idx;
                        res.read_valid  = 1'b1;
                        res.read_dev    = r_req.dev_id;
                        res.read_sector = bcm_pkg::SECTOR_BITS'(r_req.block_num)
                                          << r_sector_shift;
                        ref_we          = 1'b1;
                        ref_waddr       = pop_idx;
                        ref_wdata       = bcm_pkg::REFS_BITS'(1);
                        bind_en         = 1'b1;
                        n_free_head     = (r_free_head == bcm_pkg::IDX_BITS'(bcm_pkg::NUM_BUFFERS - 1))
                                        ? '0 : r_free_head + bcm_pkg::IDX_BITS'(1);
                        n_free_count    = r_free_count - bcm_pkg::COUNT_BITS'(1);
                    end
                end
                bcm_pkg::REQ_RELEASE, bcm_pkg::REQ_READ_FAIL: begin
                    res.out_index = r_req.buf_index;
                    if (!r_in_use[r_req.buf_index] ||
                        (r_req.req_type == bcm_pkg::REQ_RELEASE && r_refs_rd == '0)) begin
                        res.status = bcm_pkg::ST_REL_ERR;
                    end else if (r_req.req_type == bcm_pkg::REQ_RELEASE &&
                                 r_refs_rd != bcm_pkg::REFS_BITS'(1)) begin
                        // Still referenced elsewhere: just drop one count
                        res.status = bcm_pkg::ST_HELD;
                        ref_we     = 1'b1;
                        ref_wdata  = r_refs_rd - bcm_pkg::REFS_BITS'(1);
                    end else begin
                        // Last reference gone, or the read failed: unbind and return
                        res.status = bcm_pkg::ST_FREED;
                        ref_we     = 1'b1;
                        ref_wdata  = '0;
                        unbind_en  = 1'b1;
                        if (r_free_count < bcm_pkg::COUNT_BITS'(bcm_pkg::NUM_BUFFERS)) begin
                            push_en      = 1'b1;
                            n_free_count = r_free_count + bcm_pkg::COUNT_BITS'(1);
                        end
                    end
                end
                default: begin
                    res.status = bcm_pkg::ST_REFUSED;
                end
            endcase
        end
    end

    assign o_res = res;

    // Tag store and free-list pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use     <= '0;
            r_fq_ok      <= '0;
            r_free_head  <= '0;
            r_free_count <= bcm_pkg::COUNT_BITS'(bcm_pkg::NUM_BUFFERS);
        end else begin
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            if (bind_en) begin
                r_in_use[pop_idx] <= 1'b1;
            end
            if (unbind_en) begin
                r_in_use[r_req.buf_index] <= 1'b0;
            end
            if (push_en) begin
                r_fq_ok[tail_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (bind_en) begin
            r_dev[pop_idx]   <= r_req.dev_id;
            r_block[pop_idx] <= r_req.block_num;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_result_follows_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(start && !busy))
        else $error("result strobe without an accepted transaction");

    a_buffers_conserved: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_in_use) + int'(r_free_count)) == bcm_pkg::NUM_BUFFERS)
        else $error("in-use entries and free list disagree");

    a_read_only_on_miss: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.read_valid) |-> (o_res.status == bcm_pkg::ST_MISS))
        else $error("sector read raised outside a miss");

    a_miss_binds_entry: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == bcm_pkg::ST_MISS) |=> r_in_use[$past(o_res.out_index)])
        else $error("miss did not bind the granted entry");

    a_freed_unbinds_entry: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == bcm_pkg::ST_FREED) |=> !r_in_use[$past(o_res.out_index)])
        else $error("freed entry still marked in use");

endmodule

FILE: verif/block_buffer_cache_manager_tb.sv
module block_buffer_cache_manager_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 3;
    // Quiet cycles on the block that must be exceeded before a sector shift write is driven
    localparam int CFG_SETTLE     = 3;
    // Cycles with no transaction and no result before the run is abandoned
    localparam int WATCHDOG_LIMIT = 200;
    localparam int TAIL_CYCLES    = 8;
    localparam int POOL_SIZE      = 64;
    localparam int NUM_PHASES     = 9;
    // Sector shift per random phase, phase 0 in the low bits; both extremes appear
    localparam logic [3*NUM_PHASES-1:0] PHASE_SHIFTS =
        {3'd0, 3'd4, 3'd6, 3'd1, 3'd7, 3'd2, 3'd5, 3'd0, 3'd7};

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_SHIFT_WRITE,
        OP_PAUSE
    } t_op_kind;

    typedef struct {
        t_op_kind                       kind;
        bcm_pkg::t_request              req;
        logic [bcm_pkg::SHIFT_BITS-1:0] shift;
        int unsigned                    cycles;
    } t_op;

    // ------------------------------------------------------------------
    // Block connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           start       = 1'b0;
    logic                           busy;
    bcm_pkg::t_request              i_req       = '0;
    logic                           o_res_valid;
    bcm_pkg::t_result               o_res;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [bcm_pkg::SHIFT_BITS-1:0] i_cfg_data  = '0;

    block_buffer_cache_manager u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the cache: bindings, reference counts, free list
    // ------------------------------------------------------------------
    logic                           ent_used  [bcm_pkg::NUM_BUFFERS];
    logic [bcm_pkg::DEV_BITS-1:0]   ent_dev   [bcm_pkg::NUM_BUFFERS];
    logic [bcm_pkg::BLOCK_BITS-1:0] ent_blk   [bcm_pkg::NUM_BUFFERS];
    logic [bcm_pkg::REFS_BITS-1:0]  ent_refs  [bcm_pkg::NUM_BUFFERS];
    logic [bcm_pkg::IDX_BITS-1:0]   free_slot [bcm_pkg::NUM_BUFFERS];
    logic [bcm_pkg::IDX_BITS-1:0]   free_head;
    logic [bcm_pkg::COUNT_BITS-1:0] free_count;
    logic [bcm_pkg::SHIFT_BITS-1:0] sec_shift;

    t_op              pending_ops [$];   // stimulus waiting for the driver
    bcm_pkg::t_result outcome_q   [$];   // predicted results, oldest first
    int unsigned handshakes       = 0;  // request and shift-write transactions seen
    int unsigned handshake_goal   = 0;  // value of handshakes that ends the current one
    int unsigned handshakes_total = 0;  // transactions queued by the stimulus
    int unsigned fail_count       = 0;
    int unsigned quiet_cycles     = 0;
    int unsigned pause_done       = 0;
    int unsigned settle_cycles    = 0;

    logic [bcm_pkg::DEV_BITS-1:0]   pool_dev [POOL_SIZE];
    logic [bcm_pkg::BLOCK_BITS-1:0] pool_blk [POOL_SIZE];

    // Work out the result of one request and advance the shadow state
    function automatic bcm_pkg::t_result cache_outcome(input bcm_pkg::t_request rq);
        bcm_pkg::t_result             r;
        int                           hit;
        logic [bcm_pkg::IDX_BITS-1:0] slot;
        r   = '0;
        hit = -1;
        if (rq.req_type == bcm_pkg::REQ_GET) begin
            // Lowest matching entry wins
            for (int i = bcm_pkg::NUM_BUFFERS - 1; i >= 0; i--) begin
                if (ent_used[i] && ent_dev[i] == rq.dev_id && ent_blk[i] == rq.block_num) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                r.out_index = bcm_pkg::IDX_BITS'(hit);
                if (ent_refs[hit] == bcm_pkg::REFS_MAX) begin
                    // Saturated count: refuse, leave the count alone
                    r.status = bcm_pkg::ST_REFUSED;
                end else begin
                    ent_refs[hit] = ent_refs[hit] + 1'b1;
                    r.status      = bcm_pkg::ST_HIT;
                end
            end else if (free_count == 0) begin
                r.status = bcm_pkg::ST_NO_FREE;
            end else begin
                // Take the oldest freed buffer and bind it
                slot           = free_slot[free_head];
                free_head      = free_head + 1'b1;
                free_count     = free_count - 1'b1;
                ent_used[slot] = 1'b1;
                ent_dev[slot]  = rq.dev_id;
                ent_blk[slot]  = rq.block_num;
                ent_refs[slot] = bcm_pkg::REFS_BITS'(1);
                r.status       = bcm_pkg::ST_MISS;
                r.out_index    = slot;
                r.read_valid   = 1'b1;
                r.read_dev     = rq.dev_id;
                r.read_sector  = bcm_pkg::SECTOR_BITS'(rq.block_num) << sec_shift;
            end
        end else if (rq.req_type == bcm_pkg::REQ_RELEASE ||
                     rq.req_type == bcm_pkg::REQ_READ_FAIL) begin
            slot        = rq.buf_index;
            r.out_index = slot;
            if (!ent_used[slot] ||
                (rq.req_type == bcm_pkg::REQ_RELEASE && ent_refs[slot] == 0)) begin
                r.status = bcm_pkg::ST_REL_ERR;
            end else if (rq.req_type == bcm_pkg::REQ_RELEASE && ent_refs[slot] > 1) begin
                ent_refs[slot] = ent_refs[slot] - 1'b1;
                r.status       = bcm_pkg::ST_HELD;
            end else begin
                // Last reference dropped, or read failed: unbind, append to the tail
                ent_refs[slot] = '0;
                ent_used[slot] = 1'b0;
                if (free_count < bcm_pkg::NUM_BUFFERS) begin
                    free_slot[bcm_pkg::IDX_BITS'(free_head + free_count)] = slot;
                    free_count = free_count + 1'b1;
                end
                r.status = bcm_pkg::ST_FREED;
            end
        end else begin
            r.status = bcm_pkg::ST_REFUSED;
        end
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_req(input bcm_pkg::t_req_type kind,
                           input logic [bcm_pkg::DEV_BITS-1:0] dev,
                           input logic [bcm_pkg::BLOCK_BITS-1:0] blk,
                           input logic [bcm_pkg::IDX_BITS-1:0] idx);
        t_op op;
        op.kind          = OP_REQUEST;
        op.req.req_type  = kind;
        op.req.dev_id    = dev;
        op.req.block_num = blk;
        op.req.buf_index = idx;
        op.shift         = '0;
        op.cycles        = 0;
        pending_ops.push_back(op);
        handshakes_total++;
    endtask

    task automatic add_shift(input logic [bcm_pkg::SHIFT_BITS-1:0] shift);
        t_op op;
        op.kind   = OP_SHIFT_WRITE;
        op.req    = '0;
        op.shift  = shift;
        op.cycles = 0;
        pending_ops.push_back(op);
        handshakes_total++;
    endtask

    task automatic add_pause(input int unsigned cycles);
        t_op op;
        op.kind   = OP_PAUSE;
        op.req    = '0;
        op.shift  = '0;
        op.cycles = cycles;
        pending_ops.push_back(op);
    endtask

    // Replace some keys of the working set: wide random, small and near-top blocks
    task automatic refresh_pool(input int count);
        int unsigned sel;
        for (int k = 0; k < count; k++) begin
            sel           = $urandom_range(0, POOL_SIZE - 1);
            pool_dev[sel] = bcm_pkg::DEV_BITS'($urandom);
            case ($urandom_range(0, 3))
                0:       pool_blk[sel] = bcm_pkg::BLOCK_BITS'($urandom_range(0, 15));
                1:       pool_blk[sel] = '1 - bcm_pkg::BLOCK_BITS'($urandom_range(0, 15));
                default: pool_blk[sel] = bcm_pkg::BLOCK_BITS'($urandom);
            endcase
        end
    endtask

    // Gets from a working set of keys mixed with releases, read failures and noise
    task automatic random_phase(input int n, input int pool, input int get_pct,
                                input int fail_pct, input bit idling);
        int unsigned roll;
        int unsigned sel;
        for (int k = 0; k < n; k++) begin
            if (idling && $urandom_range(0, 3) == 0) begin
                add_pause($urandom_range(1, 8));
            end
            roll = $urandom_range(0, 99);
            sel  = $urandom_range(0, pool - 1);
            if (roll < get_pct) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_req(bcm_pkg::REQ_GET, bcm_pkg::DEV_BITS'($urandom),
                            bcm_pkg::BLOCK_BITS'($urandom), bcm_pkg::IDX_BITS'($urandom));
                end else begin
                    add_req(bcm_pkg::REQ_GET, pool_dev[sel], pool_blk[sel],
                            bcm_pkg::IDX_BITS'($urandom));
                end
            end else if (roll < get_pct + fail_pct) begin
                add_req(bcm_pkg::REQ_READ_FAIL, bcm_pkg::DEV_BITS'($urandom),
                        bcm_pkg::BLOCK_BITS'($urandom), bcm_pkg::IDX_BITS'($urandom));
            end else if (roll < 97) begin
                add_req(bcm_pkg::REQ_RELEASE, bcm_pkg::DEV_BITS'($urandom),
                        bcm_pkg::BLOCK_BITS'($urandom), bcm_pkg::IDX_BITS'($urandom));
            end else begin
                add_req(bcm_pkg::REQ_RESERVED, bcm_pkg::DEV_BITS'($urandom),
                        bcm_pkg::BLOCK_BITS'($urandom), bcm_pkg::IDX_BITS'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge, one transaction at a time
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic drive_start;
        logic drive_cfg;
        t_op  head;
        drive_start = start;
        drive_cfg   = i_cfg_valid;
        if (i_rst_n) begin
            // Drop the strobe once the sampler has seen the transaction complete
            if ((drive_start || drive_cfg) && handshakes == handshake_goal) begin
                drive_start = 1'b0;
                drive_cfg   = 1'b0;
            end
            if (!drive_start && !drive_cfg && pending_ops.size() != 0) begin
                head = pending_ops[0];
                case (head.kind)
                    OP_PAUSE: begin
                        pause_done++;
                        if (pause_done >= head.cycles) begin
                            pause_done = 0;
                            void'(pending_ops.pop_front());
                        end
                    end
                    OP_SHIFT_WRITE: begin
                        // Hold the write until every result is back and the block is quiet
                        if (outcome_q.size() == 0 && !busy) begin
                            settle_cycles++;
                        end else begin
                            settle_cycles = 0;
                        end
                        if (settle_cycles > CFG_SETTLE) begin
                            settle_cycles  = 0;
                            drive_cfg      = 1'b1;
                            i_cfg_data    <= head.shift;
                            handshake_goal = handshakes + 1;
                            void'(pending_ops.pop_front());
                        end
                    end
                    default: begin
                        drive_start    = 1'b1;
                        i_req         <= head.req;
                        handshake_goal = handshakes + 1;
                        void'(pending_ops.pop_front());
                    end
                endcase
            end
        end
        start       <= drive_start;
        i_cfg_valid <= drive_cfg;
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, retire results before predicting
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bcm_pkg::t_result want;
        logic             progress;
        if (i_rst_n) begin
            progress = 1'b0;
            // A result ends this cycle; its expectation was queued at an earlier edge
            if (o_res_valid) begin
                progress = 1'b1;
                if (outcome_q.size() == 0) begin
                    $error("result with nothing expected: status 0x%0h index 0x%0h",
                           o_res.status, o_res.out_index);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", 64'(want.status), 64'(o_res.status));
                    check_field("out_index", 64'(want.out_index), 64'(o_res.out_index));
                    check_field("read_valid", 64'(want.read_valid), 64'(o_res.read_valid));
                    check_field("read_dev", 64'(want.read_dev), 64'(o_res.read_dev));
                    check_field("read_sector", 64'(want.read_sector), 64'(o_res.read_sector));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sec_shift = i_cfg_data;
                handshakes++;
                progress = 1'b1;
            end
            if (start && !busy) begin
                outcome_q.push_back(cache_outcome(i_req));
                handshakes++;
                progress = 1'b1;
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: shadow reset, stimulus build, reset, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        int unsigned pool;
        for (int i = 0; i < bcm_pkg::NUM_BUFFERS; i++) begin
            ent_used[i]  = 1'b0;
            ent_dev[i]   = '0;
            ent_blk[i]   = '0;
            ent_refs[i]  = '0;
            free_slot[i] = bcm_pkg::IDX_BITS'(i);
        end
        free_head  = '0;
        free_count = bcm_pkg::COUNT_BITS'(bcm_pkg::NUM_BUFFERS);
        sec_shift  = bcm_pkg::SHIFT_RESET;
        refresh_pool(4 * POOL_SIZE);

        // Directed: field extremes and, at the reset shift, every outcome except no free buffer
        add_req(bcm_pkg::REQ_GET, '0, '0, '0);               // miss into entry 0, sector 0
        add_req(bcm_pkg::REQ_GET, '1, '1, '1);               // miss, widest sector
        add_req(bcm_pkg::REQ_GET, '0, '0, '0);               // hit, count 2
        add_req(bcm_pkg::REQ_GET, 4'd1, '0, '0);             // same block, other device: miss
        add_pause(3);
        add_req(bcm_pkg::REQ_RELEASE, '0, '0, 4'd0);         // still held
        add_req(bcm_pkg::REQ_RELEASE, '1, '1, 4'd0);         // freed to the tail
        add_req(bcm_pkg::REQ_RELEASE, '0, '0, 4'd0);         // release of an unbound entry
        add_req(bcm_pkg::REQ_RELEASE, '0, '0, 4'd15);        // never bound
        add_req(bcm_pkg::REQ_READ_FAIL, '0, '0, 4'd1);       // read failed, count 1
        add_req(bcm_pkg::REQ_READ_FAIL, '0, '0, 4'd1);       // read failed, unbound entry
        add_req(bcm_pkg::REQ_RESERVED, '1, '1, '1);          // reserved request type
        add_req(bcm_pkg::REQ_GET, '1, '1, '0);               // rebind the widest key
        add_req(bcm_pkg::REQ_GET, '1, '1, '0);               // count 2
        add_req(bcm_pkg::REQ_READ_FAIL, '0, '0, 4'd3);       // read failed with count above 1
        add_shift(3'd7);
        add_req(bcm_pkg::REQ_GET, 4'd10, 32'h8000_0001, 4'd5); // top bit by the widest step
        add_req(bcm_pkg::REQ_GET, 4'd5, 32'hFFFF_FFFF, 4'd10);
        add_shift(3'd0);
        add_req(bcm_pkg::REQ_GET, 4'd6, 32'hAAAA_AAAA, 4'd6);
        add_req(bcm_pkg::REQ_GET, 4'd9, 32'h5555_5555, 4'd9);

        // Saturate one count: miss, 254 hits, then refusal at 255
        for (int k = 0; k < 256; k++) begin
            add_req(bcm_pkg::REQ_GET, 4'd9, 32'h1234_5678, bcm_pkg::IDX_BITS'($urandom));
        end
        add_req(bcm_pkg::REQ_GET, 4'd9, 32'h1234_5678, '0);
        add_pause(2);
        // Release entries 2 and 3, get the saturated key again, then release every index once
        add_req(bcm_pkg::REQ_RELEASE, '0, '0, 4'd2);
        add_req(bcm_pkg::REQ_RELEASE, '0, '0, 4'd3);
        add_req(bcm_pkg::REQ_GET, 4'd9, 32'h1234_5678, '0);
        for (int k = 0; k < bcm_pkg::NUM_BUFFERS; k++) begin
            add_req(bcm_pkg::REQ_RELEASE, '0, '0, bcm_pkg::IDX_BITS'(k));
        end

        // Exhaust the free list with fresh keys, then clear every entry
        for (int k = 0; k < bcm_pkg::NUM_BUFFERS + 4; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                add_pause($urandom_range(1, 8));
            end
            add_req(bcm_pkg::REQ_GET, 4'd12, 32'h0000_1000 + k, bcm_pkg::IDX_BITS'($urandom));
        end
        add_req(bcm_pkg::REQ_GET, 4'd12, 32'h0000_1000, '0);
        for (int k = 0; k < bcm_pkg::NUM_BUFFERS; k++) begin
            add_req(bcm_pkg::REQ_READ_FAIL, bcm_pkg::DEV_BITS'($urandom),
                    bcm_pkg::BLOCK_BITS'($urandom),
                    bcm_pkg::IDX_BITS'($urandom_range(0, bcm_pkg::NUM_BUFFERS - 1)));
        end
        for (int k = 0; k < bcm_pkg::NUM_BUFFERS; k++) begin
            add_req(bcm_pkg::REQ_READ_FAIL, '0, '0, bcm_pkg::IDX_BITS'(k));
        end

        // Random phases: new shift, partly new working set, varying pressure on the free list;
        // the last phase runs without idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            pool = (p % 3 == 0) ? 6 : (p % 3 == 1) ? 20 : 40;
            add_shift(PHASE_SHIFTS[3*p +: 3]);
            refresh_pool(16);
            random_phase(180, pool, (p % 2 == 0) ? 70 : 55, (p % 2 == 0) ? 4 : 10,
                         p != NUM_PHASES - 1 && $urandom_range(0, 3) != 0);
        end

        // Hold reset for the first edges, release it on a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transaction and every result, then a short tail
        while (handshakes != handshakes_total || outcome_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
